// ===== src/vpds_pkg.sv =====
// Shared types, constants and helpers for the vertex projection / depth shade pipeline.
// No dependencies.
package vpds_pkg;

    localparam int COORD_W   = 32;
    localparam int TRIG_W    = 16;
    localparam int TRIG_FRAC = 14;
    localparam int PROD_W    = COORD_W + TRIG_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int DEPTH_W   = 31;
    localparam int DIM_W     = 15;
    localparam int NUM_W     = 49;
    localparam int REM_W     = 48;
    localparam int DEN_W     = DEPTH_W + 1;
    localparam int QUO_W     = 16;
    localparam int CH_W      = 8;
    localparam int CREM_W    = DEPTH_W + CH_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 31;

    localparam int ROT_STAGES   = 6;
    localparam int SETUP_STAGES = 3;
    localparam int PIPE_DEPTH   = ROT_STAGES + SETUP_STAGES + QUO_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_CUBE_COS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUBE_SIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_COS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_SIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_COS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_SIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_NEAR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_FAR   = 3'd7;

    localparam logic [1:0] CLS_BASE  = 2'd0;
    localparam logic [1:0] CLS_WHITE = 2'd1;
    localparam logic [1:0] CLS_BLEND = 2'd2;

    localparam logic signed [COORD_W-1:0] DEPTH_MIN = 32'sd6554;

    // index 0 red, 1 green, 2 blue
    localparam logic [2:0][CH_W-1:0] BASE_RGB  = {8'd55, 8'd33, 8'd190};
    localparam logic [2:0][CH_W-1:0] WHITE_RGB = {8'd245, 8'd245, 8'd245};
    localparam logic [2:0][CH_W-1:0] DELTA_RGB = {8'd190, 8'd212, 8'd55};

    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-COORD_W+1){1'b0}},
                                                 {(COORD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-COORD_W+1){1'b1}},
                                                 {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [TRIG_W-1:0] cube_cos;
        logic signed [TRIG_W-1:0] cube_sin;
        logic signed [TRIG_W-1:0] yaw_cos;
        logic signed [TRIG_W-1:0] yaw_sin;
        logic signed [TRIG_W-1:0] tilt_cos;
        logic signed [TRIG_W-1:0] tilt_sin;
    } trig_t;

    typedef struct packed {
        logic [REM_W-1:0]             rx;
        logic [QUO_W-1:0]             qx;
        logic                         x_lo;
        logic                         x_hi;
        logic [REM_W-1:0]             ry;
        logic [QUO_W-1:0]             qy;
        logic                         y_lo;
        logic                         y_hi;
        logic [DEN_W-1:0]             den;
        logic [2:0][CREM_W-1:0]       rc;
        logic [2:0][CH_W-1:0]         qc;
        logic [DEPTH_W-1:0]           span;
        logic [1:0]                   cls;
        logic [DEPTH_W-1:0]           depth;
    } div_t;

    typedef struct packed {
        logic signed [QUO_W-1:0] sx;
        logic signed [QUO_W-1:0] sy;
        logic [DEPTH_W-1:0]      depth;
        logic [2:0][CH_W-1:0]    rgb;
    } result_t;

    // floor by 2^14, then saturate to 32-bit signed
    function automatic logic signed [COORD_W-1:0] mac_round(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] t;
        t = s >>> TRIG_FRAC;
        if (t > SAT_HI)
            t = SAT_HI;
        else if (t < SAT_LO)
            t = SAT_LO;
        return t[COORD_W-1:0];
    endfunction

endpackage

// ===== src/vpds_rotate.sv =====
// Three chained Q2.14 rotations (cube about z, yaw, pitch), six register stages.
// Depends on vpds_pkg.
module vpds_rotate (
    input  logic                            clk,
    input  logic                            en,
    input  vpds_pkg::trig_t                 trig,
    input  logic signed [vpds_pkg::COORD_W-1:0] x,
    input  logic signed [vpds_pkg::COORD_W-1:0] y,
    input  logic signed [vpds_pkg::COORD_W-1:0] z,
    output logic signed [vpds_pkg::COORD_W-1:0] x2,
    output logic signed [vpds_pkg::COORD_W-1:0] y3,
    output logic signed [vpds_pkg::COORD_W-1:0] z3
);
    import vpds_pkg::*;

    logic signed [PROD_W-1:0]  a0_reg, a1_reg, a2_reg, a3_reg;
    logic signed [COORD_W-1:0] za_reg;
    logic signed [COORD_W-1:0] x1_reg, y1_reg, zb_reg;
    logic signed [PROD_W-1:0]  b0_reg, b1_reg, b2_reg, b3_reg;
    logic signed [COORD_W-1:0] yb_reg;
    logic signed [COORD_W-1:0] x2b_reg, z2_reg, yc_reg;
    logic signed [PROD_W-1:0]  c0_reg, c1_reg, c2_reg, c3_reg;
    logic signed [COORD_W-1:0] x2c_reg;
    logic signed [COORD_W-1:0] x2d_reg, y3_reg, z3_reg;

    function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
        return {p[PROD_W-1], p};
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg  <= x * trig.cube_cos;
            a1_reg  <= y * trig.cube_sin;
            a2_reg  <= y * trig.cube_cos;
            a3_reg  <= x * trig.cube_sin;
            za_reg  <= z;

            x1_reg  <= mac_round(ext(a0_reg) - ext(a1_reg));
            y1_reg  <= mac_round(ext(a2_reg) + ext(a3_reg));
            zb_reg  <= za_reg;

            b0_reg  <= x1_reg * trig.yaw_cos;
            b1_reg  <= zb_reg * trig.yaw_sin;
            b2_reg  <= zb_reg * trig.yaw_cos;
            b3_reg  <= x1_reg * trig.yaw_sin;
            yb_reg  <= y1_reg;

            x2b_reg <= mac_round(ext(b0_reg) + ext(b1_reg));
            z2_reg  <= mac_round(ext(b2_reg) - ext(b3_reg));
            yc_reg  <= yb_reg;

            c0_reg  <= yc_reg * trig.tilt_cos;
            c1_reg  <= z2_reg * trig.tilt_sin;
            c2_reg  <= yc_reg * trig.tilt_sin;
            c3_reg  <= z2_reg * trig.tilt_cos;
            x2c_reg <= x2b_reg;

            y3_reg  <= mac_round(ext(c0_reg) - ext(c1_reg));
            z3_reg  <= mac_round(ext(c2_reg) + ext(c3_reg));
            x2d_reg <= x2c_reg;
        end
    end

    assign x2 = x2d_reg;
    assign y3 = y3_reg;
    assign z3 = z3_reg;

endmodule

// ===== src/vpds_setup.sv =====
// Depth clamp, fog classification and divider operand setup, three register stages.
// Depends on vpds_pkg.
module vpds_setup #(
    parameter int SCREEN_WIDTH  = 450,
    parameter int SCREEN_HEIGHT = 450
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [vpds_pkg::DEPTH_W-1:0]        fog_near,
    input  logic [vpds_pkg::DEPTH_W-1:0]        fog_far,
    input  logic signed [vpds_pkg::COORD_W-1:0] x2,
    input  logic signed [vpds_pkg::COORD_W-1:0] y3,
    input  logic signed [vpds_pkg::COORD_W-1:0] z3,
    output vpds_pkg::div_t                      op
);
    import vpds_pkg::*;

    localparam logic signed [DIM_W-1:0] W_S = DIM_W'(SCREEN_WIDTH);
    localparam logic signed [DIM_W-1:0] H_S = DIM_W'(SCREEN_HEIGHT);

    logic [DEPTH_W-1:0]        d;
    logic [DEPTH_W-1:0]        d_reg, d1_reg;
    logic signed [COORD_W:0]   ax_reg, ay_reg;
    logic [DEPTH_W-1:0]        n_reg, m_reg, m1_reg;
    logic [1:0]                cls_reg, cls1_reg;
    logic signed [NUM_W-1:0]   nx_reg, ny_reg;
    logic [2:0][CREM_W-1:0]    nc_reg;
    div_t                      op_reg;
    div_t                      op_next;

    assign d = (z3 <= DEPTH_MIN) ? DEPTH_W'(DEPTH_MIN) : z3[DEPTH_W-1:0];

    always_comb
    begin
        logic signed [NUM_W-1:0] den_hi;
        den_hi          = $signed({1'b0, d1_reg, 1'b0, 16'b0});
        op_next         = '0;
        op_next.rx      = nx_reg[REM_W-1:0];
        op_next.ry      = ny_reg[REM_W-1:0];
        op_next.x_lo    = nx_reg[NUM_W-1];
        op_next.y_lo    = ny_reg[NUM_W-1];
        op_next.x_hi    = nx_reg >= den_hi;
        op_next.y_hi    = ny_reg >= den_hi;
        op_next.den     = {d1_reg, 1'b0};
        op_next.rc      = nc_reg;
        op_next.span    = m1_reg;
        op_next.cls     = cls1_reg;
        op_next.depth   = d1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg  <= d;
            ax_reg <= {x2[COORD_W-1], x2} + $signed({2'b0, d});
            ay_reg <= $signed({2'b0, d}) - {y3[COORD_W-1], y3};
            n_reg  <= d - fog_near;
            m_reg  <= fog_far - fog_near;
            if (d <= fog_near)
                cls_reg <= CLS_BASE;
            else if (d >= fog_far)
                cls_reg <= CLS_WHITE;
            else
                cls_reg <= CLS_BLEND;

            // offset by 2^15 divisors so the quotient is unsigned
            nx_reg   <= ax_reg * W_S + $signed({2'b0, d_reg, 16'b0});
            ny_reg   <= ay_reg * H_S + $signed({2'b0, d_reg, 16'b0});
            for (int i = 0; i < 3; i++)
                nc_reg[i] <= DELTA_RGB[i] * n_reg;
            d1_reg   <= d_reg;
            m1_reg   <= m_reg;
            cls1_reg <= cls_reg;

            op_reg <= op_next;
        end
    end

    assign op = op_reg;

endmodule

// ===== src/vpds_divide.sv =====
// Pipelined restoring divider: one quotient bit per stage for both screen axes,
// and one bit per stage for the three colour blends in the last eight stages.
// Depends on vpds_pkg.
module vpds_divide (
    input  logic           clk,
    input  logic           en,
    input  vpds_pkg::div_t op_in,
    output vpds_pkg::div_t op_out
);
    import vpds_pkg::*;

    div_t st_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int S = QUO_W - 1 - k;
        div_t cur;
        div_t nxt;

        if (k == 0)
        begin : g_first
            assign cur = op_in;
        end
        else
        begin : g_rest
            assign cur = st_reg[k-1];
        end

        always_comb
        begin
            logic [REM_W-1:0]  trial;
            logic [CREM_W-1:0] ctrial;
            nxt   = cur;
            trial = {{(REM_W-DEN_W){1'b0}}, cur.den} << S;
            if (cur.rx >= trial)
            begin
                nxt.rx    = cur.rx - trial;
                nxt.qx[S] = 1'b1;
            end
            if (cur.ry >= trial)
            begin
                nxt.ry    = cur.ry - trial;
                nxt.qy[S] = 1'b1;
            end
            ctrial = {{CH_W{1'b0}}, cur.span} << S;
            if (S < CH_W)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cur.rc[i] >= ctrial)
                    begin
                        nxt.rc[i]                    = cur.rc[i] - ctrial;
                        nxt.qc[i][S % CH_W]          = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= nxt;
        end
    end

    assign op_out = st_reg[QUO_W-1];

endmodule

// ===== src/vertex_project_depth_shade.sv =====
// Vertex rotate / perspective project / depth fog pipeline, top level.
// Vertices pass through the rotate, setup and divider pipelines and the output
// registers. Throughput: one vertex per cycle while the skid entry is empty, set by the
// one-bit-per-stage divider pipeline. A one-entry skid holds a result while the
// output is stalled. Reset clears valid state and loads the register defaults.
// Depends on vpds_pkg, vpds_rotate, vpds_setup, vpds_divide.
module vertex_project_depth_shade #(
    parameter int SCREEN_WIDTH  = 450,
    parameter int SCREEN_HEIGHT = 450
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [vpds_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vpds_pkg::CFG_DAT_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [vpds_pkg::COORD_W-1:0]   vertex_x,
    input  logic signed [vpds_pkg::COORD_W-1:0]   vertex_y,
    input  logic signed [vpds_pkg::COORD_W-1:0]   vertex_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [vpds_pkg::QUO_W-1:0]     screen_x,
    output logic signed [vpds_pkg::QUO_W-1:0]     screen_y,
    output logic [vpds_pkg::DEPTH_W-1:0]          view_depth,
    output logic [vpds_pkg::CH_W-1:0]             red,
    output logic [vpds_pkg::CH_W-1:0]             green,
    output logic [vpds_pkg::CH_W-1:0]             blue
);
    import vpds_pkg::*;

    trig_t                     trig_reg;
    logic [DEPTH_W-1:0]        fog_near_reg, fog_far_reg;
    logic [PIPE_DEPTH-1:0]     valid_reg;
    logic                      en;
    logic signed [COORD_W-1:0] x2, y3, z3;
    div_t                      setup_op, div_op;
    result_t                   res;
    result_t                   res_reg, out_reg, skid_reg;
    logic                      out_valid_reg, skid_valid_reg;

    // pipeline moves unless the skid entry is occupied
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_reg.cube_cos  <= 16'sd16384;
            trig_reg.cube_sin  <= '0;
            trig_reg.yaw_cos   <= 16'sd16384;
            trig_reg.yaw_sin   <= '0;
            trig_reg.tilt_cos  <= 16'sd16384;
            trig_reg.tilt_sin  <= '0;
            fog_near_reg       <= 31'd65536;
            fog_far_reg        <= 31'd3276800;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CUBE_COS:  trig_reg.cube_cos  <= cfg_data[TRIG_W-1:0];
                REG_CUBE_SIN:  trig_reg.cube_sin  <= cfg_data[TRIG_W-1:0];
                REG_YAW_COS:   trig_reg.yaw_cos   <= cfg_data[TRIG_W-1:0];
                REG_YAW_SIN:   trig_reg.yaw_sin   <= cfg_data[TRIG_W-1:0];
                REG_TILT_COS:  trig_reg.tilt_cos  <= cfg_data[TRIG_W-1:0];
                REG_TILT_SIN:  trig_reg.tilt_sin  <= cfg_data[TRIG_W-1:0];
                REG_FOG_NEAR:  fog_near_reg       <= cfg_data[DEPTH_W-1:0];
                REG_FOG_FAR:   fog_far_reg        <= cfg_data[DEPTH_W-1:0];
            endcase
        end
    end

    vpds_rotate u_rotate (
        .clk  (clk),
        .en   (en),
        .trig (trig_reg),
        .x    (vertex_x),
        .y    (vertex_y),
        .z    (vertex_z),
        .x2   (x2),
        .y3   (y3),
        .z3   (z3)
    );

    vpds_setup #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_setup (
        .clk      (clk),
        .en       (en),
        .fog_near (fog_near_reg),
        .fog_far  (fog_far_reg),
        .x2       (x2),
        .y3       (y3),
        .z3       (z3),
        .op       (setup_op)
    );

    vpds_divide u_divide (
        .clk    (clk),
        .en     (en),
        .op_in  (setup_op),
        .op_out (div_op)
    );

    // saturate and remove the 2^15 offset; select or blend the colour
    always_comb
    begin
        res       = '0;
        res.depth = div_op.depth;
        if (div_op.x_lo)
            res.sx = 16'sh8000;
        else if (div_op.x_hi)
            res.sx = 16'sh7fff;
        else
            res.sx = {~div_op.qx[QUO_W-1], div_op.qx[QUO_W-2:0]};
        if (div_op.y_lo)
            res.sy = 16'sh8000;
        else if (div_op.y_hi)
            res.sy = 16'sh7fff;
        else
            res.sy = {~div_op.qy[QUO_W-1], div_op.qy[QUO_W-2:0]};
        for (int i = 0; i < 3; i++)
        begin
            unique case (div_op.cls)
                CLS_BASE:  res.rgb[i] = BASE_RGB[i];
                CLS_WHITE: res.rgb[i] = WHITE_RGB[i];
                CLS_BLEND: res.rgb[i] = BASE_RGB[i] + div_op.qc[i];
                default:   res.rgb[i] = BASE_RGB[i];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_valid};
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= valid_reg[PIPE_DEPTH-1];
                out_reg       <= res_reg;
            end
            else
            begin
                skid_valid_reg <= valid_reg[PIPE_DEPTH-1];
                skid_reg       <= res_reg;
            end
        end
        else if (!out_stall)
        begin
            out_reg        <= skid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign screen_x   = out_reg.sx;
    assign screen_y   = out_reg.sy;
    assign view_depth = out_reg.depth;
    assign red        = out_reg.rgb[0];
    assign green      = out_reg.rgb[1];
    assign blue       = out_reg.rgb[2];

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output result");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid filled while output was free");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> !skid_valid_reg)
        else $error("skid entry not drained after output transfer");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for vertex_project_depth_shade: rotation, projection and fog.
// Predicts each vertex in a scoreboard class and checks results in order.
// Depends on vpds_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
    import vpds_pkg::*;

    localparam int SCR_W       = 450;
    localparam int SCR_H       = 450;
    localparam int LATENCY     = 26;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [30:0]        depth;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
    } pixel_t;

    class projection_board;
        logic signed [15:0] trig [6];
        longint             near_d;
        longint             far_d;
        pixel_t             pending [$];
        int                 errors;

        function new();
            trig[REG_CUBE_COS]  = 16384;
            trig[REG_CUBE_SIN]  = 0;
            trig[REG_YAW_COS]   = 16384;
            trig[REG_YAW_SIN]   = 0;
            trig[REG_TILT_COS]  = 16384;
            trig[REG_TILT_SIN]  = 0;
            near_d = 65536;
            far_d  = 3276800;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [30:0] val);
            if (idx == REG_FOG_NEAR)
                near_d = longint'(val);
            else if (idx == REG_FOG_FAR)
                far_d = longint'(val);
            else
                trig[idx] = val[15:0];
        endfunction

        static function longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0)
                q--;
            return q;
        endfunction

        static function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        static function longint rot(longint a, longint c, longint b, longint s);
            return clip(fdiv(a * c + b * s, 16384), -64'sd2147483648, 64'sd2147483647);
        endfunction

        function void note_vertex(logic signed [31:0] vx, logic signed [31:0] vy,
                                  logic signed [31:0] vz);
            longint x, y, z, cc, cs, yc, ys, pc, ps, x1, y1, x2, z2, y3, z3, d, c;
            longint base_c [3];
            longint white_c;
            pixel_t p;
            base_c = '{190, 33, 55};
            white_c = 245;
            x = vx; y = vy; z = vz;
            cc = trig[REG_CUBE_COS];  cs = trig[REG_CUBE_SIN];
            yc = trig[REG_YAW_COS];   ys = trig[REG_YAW_SIN];
            pc = trig[REG_TILT_COS];  ps = trig[REG_TILT_SIN];
            x1 = rot(x, cc, y, -cs);
            y1 = rot(y, cc, x, cs);
            x2 = rot(x1, yc, z, ys);
            z2 = rot(x1, -ys, z, yc);
            y3 = rot(y1, pc, z2, -ps);
            z3 = rot(y1, ps, z2, pc);
            d = (z3 <= 6554) ? 6554 : z3;
            p.sx = 16'(clip(fdiv((x2 + d) * SCR_W, 2 * d), -32768, 32767));
            p.sy = 16'(clip(fdiv((d - y3) * SCR_H, 2 * d), -32768, 32767));
            p.depth = 31'(d);
            for (int i = 0; i < 3; i++) begin
                if (d <= near_d)
                    c = base_c[i];
                else if (d >= far_d)
                    c = white_c;
                else
                    c = base_c[i] + ((white_c - base_c[i]) * (d - near_d)) / (far_d - near_d);
                if (i == 0) p.r = 8'(c);
                else if (i == 1) p.g = 8'(c);
                else p.b = 8'(c);
            end
            pending = {pending, p};
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t e;
            if (pending.size() == 0) begin
                $error("unexpected result sx=%0d sy=%0d", got.sx, got.sy);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.sx !== e.sx) begin
                $error("screen_x exp %0d got %0d", e.sx, got.sx); errors++;
            end
            if (got.sy !== e.sy) begin
                $error("screen_y exp %0d got %0d", e.sy, got.sy); errors++;
            end
            if (got.depth !== e.depth) begin
                $error("view_depth exp %0d got %0d", e.depth, got.depth); errors++;
            end
            if (got.r !== e.r) begin
                $error("red exp %0d got %0d", e.r, got.r); errors++;
            end
            if (got.g !== e.g) begin
                $error("green exp %0d got %0d", e.g, got.g); errors++;
            end
            if (got.b !== e.b) begin
                $error("blue exp %0d got %0d", e.b, got.b); errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [30:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] vertex_x = '0;
    logic signed [31:0] vertex_y = '0;
    logic signed [31:0] vertex_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [30:0]        view_depth;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;

    projection_board board = new();
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_off = 1'b0;
    int  quiet_cycles = 0;

    always #6 clk = ~clk;

    vertex_project_depth_shade u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .vertex_x   (vertex_x),
        .vertex_y   (vertex_y),
        .vertex_z   (vertex_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .view_depth (view_depth),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    // result side: check transfers, drive random stall for the next edge
    always @(posedge clk) begin
        pixel_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.sx = screen_x; got.sy = screen_y; got.depth = view_depth;
            got.r = red; got.g = green; got.b = blue;
            board.check_pixel(got);
        end
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("vertex_project_depth_shade verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [30:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        board.write_reg(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // presents one vertex, holds it until the transfer edge; valid stays up
    // so the next vertex can follow back to back
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        vertex_x <= x;
        vertex_y <= y;
        vertex_z <= z;
        do
            @(posedge clk);
        while (in_stall);
        board.note_vertex(x, y, z);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            2: return $urandom_range(0, 3) == 0 ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_depth();
        if ($urandom_range(3) == 0)
            return rand_coord();
        return $urandom_range(1 << 14, 1 << 23);
    endfunction

    function automatic logic [15:0] rand_trig();
        case ($urandom_range(7))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom());
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic random_setting(bit extremes);
        for (int i = 0; i < 6; i++)
            write_reg(i[2:0], extremes ? ($urandom_range(1) ? 31'h7fff : 31'h8000)
                                       : {15'd0, rand_trig()});
        write_reg(REG_FOG_NEAR, extremes ? 31'd0 : 31'($urandom_range(0, 1 << 19)));
        write_reg(REG_FOG_FAR, extremes ? 31'h7fffffff : 31'($urandom_range(0, 1 << 23)));
    endtask

    task automatic random_vertices(int n);
        for (int i = 0; i < n; i++)
            send_vertex(rand_coord(), rand_coord(), rand_depth());
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default setting, extremes, depth clamp, fog boundaries
        send_vertex(0, 0, 32'sh00010000);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_vertex(32'sh7fffffff, 32'sh80000000, 0);
        send_vertex(0, 0, 6554);
        send_vertex(0, 0, 6555);
        send_vertex(32'sh00010000, -32'sh00010000, 65536);
        send_vertex(0, 0, 65537);
        send_vertex(0, 0, 3276800);
        send_vertex(0, 0, 3276799);
        send_vertex(32'sh00640000, 32'sh00640000, 32'sh00020000);
        wait_drain();
        // rotation overflow with out-of-range trig values
        random_setting(1'b1);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send_vertex(32'sh12345678, -32'sh0abcdef0, 32'sh00500000);
        wait_drain();
        // far not above near
        write_reg(REG_FOG_NEAR, 31'd1 << 20);
        write_reg(REG_FOG_FAR, 31'd1 << 18);
        send_vertex(0, 0, 1 << 20);
        send_vertex(0, 0, (1 << 20) + 1);
        send_vertex(0, 0, 1 << 18);
        wait_drain();

        for (int ph = 0; ph < 5; ph++) begin
            random_setting(1'b0);
            send_idle_pct = ph == 1 || ph == 3 ? 76 : 0;
            stall_pct = ph == 2 || ph == 3 ? 76 : 0;
            if (ph == 3) begin
                send_idle_pct = 14;
                stall_pct = 14;
            end
            random_vertices(110);
            wait_drain();
        end

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        stall_pct = 10;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            random_vertices(90);
        join
        // sender pauses until every result is back, then resumes
        wait_drain();
        random_setting(1'b0);
        random_vertices(60);
        wait_drain();

        if (board.errors == 0)
            $display("vertex_project_depth_shade verification clean");
        else
            $display("vertex_project_depth_shade verification failed");
        $finish;
    end
endmodule
